// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

// property checked only while reset is released
`define ASSERT_SYNC(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== hw/rtl/cbc_pkg.sv =====
// types and constants of the cartridge bank controller
package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int PHYS_W     = 23;
    localparam int TARGET_W   = 2;
    localparam int CTYPE_W    = 3;
    localparam int CFG_DATA_W = 3;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int ROM_OFS_W  = 14;
    localparam int RAM_OFS_W  = 13;

    localparam logic [CTYPE_W-1:0] CTRL_NONE = 3'd0;
    localparam logic [CTYPE_W-1:0] CTRL_MBC1 = 3'd1;
    localparam logic [CTYPE_W-1:0] CTRL_MBC2 = 3'd2;
    localparam logic [CTYPE_W-1:0] CTRL_MBC3 = 3'd3;
    localparam logic [CTYPE_W-1:0] CTRL_MBC5 = 3'd4;

    localparam logic CFG_IDX_CTYPE  = 1'b0;
    localparam logic CFG_IDX_RUMBLE = 1'b1;

    localparam logic [TARGET_W-1:0] TGT_ROM  = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_RAM  = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_CTRL = 2'd2;
    localparam logic [TARGET_W-1:0] TGT_NONE = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [DATA_W-1:0] MBC3_RAM_LIMIT = 8'h08;
    localparam logic [DATA_W-1:0] MBC3_CLK_LAST  = 8'h0C;

    typedef struct packed {
        logic [DATA_W-1:0]     low_bank;
        logic [DATA_W-1:0]     high_bank;
        logic                  banking_mode;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  rumble_on;
    } t_bank_state;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [PHYS_W-1:0]   phys_addr;
        logic                rejected;
        logic                rumble;
    } t_result;

endpackage

// ===== hw/rtl/cbc_xlate.sv =====
// address translation and bank register update for one bus word
module cbc_xlate (
    input  logic [cbc_pkg::CTYPE_W-1:0] i_ctype,
    input  logic                        i_rumble_present,
    input  cbc_pkg::t_bank_state        i_state,
    input  logic                        i_operation,
    input  logic [cbc_pkg::ADDR_W-1:0]  i_address,
    input  logic [cbc_pkg::DATA_W-1:0]  i_write_data,
    output cbc_pkg::t_bank_state        o_state,
    output cbc_pkg::t_result            o_result
);

    logic                       is_ctrl;
    logic                       rejected;
    cbc_pkg::t_bank_state       nxt;
    logic [4:0]                 low5;

    assign is_ctrl = (i_operation == cbc_pkg::OP_WRITE) && !i_address[15];

    always_comb begin
        nxt      = i_state;
        rejected = 1'b0;
        low5     = 5'd0;
        if (is_ctrl) begin
            case (i_ctype)
                cbc_pkg::CTRL_MBC1: begin
                    if (i_address[14:13] != 2'b00) begin
                        case (i_address[14:13])
                            2'b01:   nxt.low_bank = i_write_data;
                            2'b10:   nxt.high_bank = i_write_data;
                            default: nxt.banking_mode = i_write_data[0];
                        endcase
                        low5 = nxt.low_bank[4:0];
                        nxt.rom_bank = {2'b00, nxt.high_bank[1:0],
                                        (low5 == 5'd0) ? 5'd1 : low5};
                        nxt.ram_bank = nxt.banking_mode ? {2'b00, nxt.high_bank[1:0]}
                                                        : 4'd0;
                    end
                end
                cbc_pkg::CTRL_MBC2: begin
                    if (i_address[14]) begin
                        rejected = 1'b1;
                    end else if (i_address[8]) begin
                        nxt.rom_bank = (i_write_data[3:0] == 4'd0) ? 9'd1
                                       : {5'b0, i_write_data[3:0]};
                    end
                end
                cbc_pkg::CTRL_MBC3: begin
                    case (i_address[14:13])
                        2'b01: begin
                            nxt.rom_bank = (i_write_data[6:0] == 7'd0) ? 9'd1
                                           : {2'b00, i_write_data[6:0]};
                        end
                        2'b10: begin
                            if (i_write_data < cbc_pkg::MBC3_RAM_LIMIT) begin
                                nxt.ram_bank = i_write_data[3:0];
                            end else begin
                                rejected = (i_write_data > cbc_pkg::MBC3_CLK_LAST);
                            end
                        end
                        default: ;
                    endcase
                end
                cbc_pkg::CTRL_MBC5: begin
                    case (i_address[14:13])
                        2'b01: begin
                            if (!i_address[12]) begin
                                nxt.low_bank = i_write_data;
                            end else begin
                                nxt.high_bank = {7'b0, i_write_data[0]};
                            end
                            nxt.rom_bank = {nxt.high_bank[0], nxt.low_bank};
                        end
                        2'b10: begin
                            if (i_rumble_present) begin
                                nxt.ram_bank  = {1'b0, i_write_data[2:0]};
                                nxt.rumble_on = i_write_data[3];
                            end else begin
                                nxt.ram_bank = i_write_data[3:0];
                            end
                        end
                        2'b11:   rejected = 1'b1;
                        default: ;
                    endcase
                end
                default: rejected = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_result.rejected = rejected;
        o_result.rumble   = nxt.rumble_on;
        if (is_ctrl) begin
            o_result.target    = cbc_pkg::TGT_CTRL;
            o_result.phys_addr = {7'b0, i_address};
        end else if (i_address[15:14] == 2'b00) begin
            o_result.target    = cbc_pkg::TGT_ROM;
            o_result.phys_addr = {7'b0, i_address};
        end else if (i_address[15:14] == 2'b01) begin
            o_result.target    = cbc_pkg::TGT_ROM;
            o_result.phys_addr = {i_state.rom_bank, i_address[cbc_pkg::ROM_OFS_W-1:0]};
        end else if (i_address[15:13] == 3'b101) begin
            o_result.target    = cbc_pkg::TGT_RAM;
            o_result.phys_addr = {6'b0, i_state.ram_bank,
                                  i_address[cbc_pkg::RAM_OFS_W-1:0]};
        end else begin
            o_result.target    = cbc_pkg::TGT_NONE;
            o_result.phys_addr = {7'b0, i_address};
        end
    end

    assign o_state = nxt;

endmodule

// ===== hw/rtl/cartridge_bank_controller_core.sv =====
// cartridge bank controller top level
// a word accepted into the input stage registers its result in the result stage once the output is free
// throughput: one word per cycle while i_stall does not hold the result, bank state updated from the input stage
// bank registers are read and written in that one stage, so back-to-back words
// always see the effect of the word before them
// synchronous reset: control type none, rom bank 1, all other bank state zero
module cartridge_bank_controller_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_operation,
    input  logic [cbc_pkg::ADDR_W-1:0]       i_address,
    input  logic [cbc_pkg::DATA_W-1:0]       i_write_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [cbc_pkg::TARGET_W-1:0]     o_target,
    output logic [cbc_pkg::PHYS_W-1:0]       o_phys_addr,
    output logic                             o_rejected,
    output logic                             o_rumble
);

    logic [cbc_pkg::CTYPE_W-1:0] r_ctype;
    logic                        r_rumble_present;

    logic                        r_in_valid;
    logic                        r_in_operation;
    logic [cbc_pkg::ADDR_W-1:0]  r_in_address;
    logic [cbc_pkg::DATA_W-1:0]  r_in_write_data;

    cbc_pkg::t_bank_state        r_state;
    cbc_pkg::t_bank_state        n_state;
    cbc_pkg::t_result            n_result;
    cbc_pkg::t_result            r_result;
    logic                        r_out_valid;

    logic                        out_free;
    logic                        advance;
    logic                        accept;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctype          <= cbc_pkg::CTRL_NONE;
            r_rumble_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbc_pkg::CFG_IDX_CTYPE:  r_ctype <= i_cfg_data;
                cbc_pkg::CFG_IDX_RUMBLE: r_rumble_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_operation  <= i_operation;
            r_in_address    <= i_address;
            r_in_write_data <= i_write_data;
        end
    end

    cbc_xlate u_xlate (
        .i_ctype          (r_ctype),
        .i_rumble_present (r_rumble_present),
        .i_state          (r_state),
        .i_operation      (r_in_operation),
        .i_address        (r_in_address),
        .i_write_data     (r_in_write_data),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // bank state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.low_bank     <= '0;
            r_state.high_bank    <= '0;
            r_state.banking_mode <= 1'b0;
            r_state.rom_bank     <= cbc_pkg::ROM_BANK_W'(1);
            r_state.ram_bank     <= '0;
            r_state.rumble_on    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_target    = r_result.target;
    assign o_phys_addr = r_result.phys_addr;
    assign o_rejected  = r_result.rejected;
    assign o_rumble    = r_result.rumble;

endmodule

// ===== hw/rtl/cbc_checker.sv =====
// port-level checks for the cartridge bank controller
`include "assert_macros.svh"

module cbc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic [cbc_pkg::TARGET_W-1:0]     o_target,
    input  logic [cbc_pkg::PHYS_W-1:0]       o_phys_addr,
    input  logic                             o_rejected,
    input  logic                             o_rumble
);

    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_target) && $stable(o_phys_addr) && $stable(o_rejected) && $stable(o_rumble), "stalled result word changed")

    `ASSERT_SYNC(a_reject_ctrl, i_clk, i_rst_n, o_valid && o_rejected |-> o_target == cbc_pkg::TGT_CTRL, "reject flagged on non-control word")

    `ASSERT_SYNC(a_ram_range, i_clk, i_rst_n, o_valid && o_target == cbc_pkg::TGT_RAM |-> o_phys_addr[22:17] == 6'd0, "ram address beyond sixteen banks")

    `ASSERT_SYNC(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid, "stalled input word dropped")

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_target    (o_target),
    .o_phys_addr (o_phys_addr),
    .o_rejected  (o_rejected),
    .o_rumble    (o_rumble)
);
